FILE: hw/rtl/abkf_pkg.sv
// Shared types, codes and helpers of the angle and gyro bias Kalman filter.
package abkf_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] RegAngleNoise   = 2'd0;
  localparam logic [1:0] RegBiasNoise    = 2'd1;
  localparam logic [1:0] RegMeasureNoise = 2'd2;

  // Reset values of the noise registers, unsigned Q3.28
  localparam logic [30:0] AngleNoiseRst   = 31'd268435;
  localparam logic [30:0] BiasNoiseRst    = 31'd805306;
  localparam logic [30:0] MeasureNoiseRst = 31'd8053064;

  // Datapath operations, issued in code order; M_ multiplies, W_ writes back
  typedef enum logic [4:0] {
    OP_M_ANG = 5'd0,
    OP_W_ANG = 5'd1,
    OP_M_T   = 5'd2,
    OP_W_T   = 5'd3,
    OP_M_P00 = 5'd4,
    OP_W_P00 = 5'd5,
    OP_M_P11 = 5'd6,
    OP_W_P11 = 5'd7,
    OP_DIV0  = 5'd8,
    OP_DIV1  = 5'd9,
    OP_M_A   = 5'd10,
    OP_W_A   = 5'd11,
    OP_M_B   = 5'd12,
    OP_W_B   = 5'd13,
    OP_M_C   = 5'd14,
    OP_W_C   = 5'd15,
    OP_M_D   = 5'd16,
    OP_W_D   = 5'd17,
    OP_M_E   = 5'd18,
    OP_W_E   = 5'd19,
    OP_M_F   = 5'd20,
    OP_W_F   = 5'd21,
    OP_NOP   = 5'd22
  } op_e;

  localparam logic [4:0] LastStep = 5'd21;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_STEP = 4'b0010,
    ST_DIVW = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    op_e  op;
    logic div_start;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
  } status_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Sign-extend a 32-bit value to 72 bits
  function automatic logic signed [71:0] sx32(input logic signed [31:0] v);
    return {{40{v[31]}}, v};
  endfunction

endpackage

FILE: hw/rtl/angle_bias_kalman_filter_top.sv
// Top level of the two-state angle and gyro bias Kalman filter.
//
//   channel   direction  payload
//   s_axis    in         measured_angle, angular_rate, time_step
//   m_axis    out        angle_estimate, bias_estimate
//   cfg       in         register index, write data (noise registers)
//
// Each item passes through the accept state, 20 multiply and write-back steps on
// one shared 36x33 multiplier, two gain divisions in the restoring divider (which
// skips the bit loop when the gain is zero or saturates), and the output state.
// Reset clears the estimates and covariance and restores the noise defaults.
// The output register holds a result until taken; the next item is accepted
// meanwhile, and only its final hand-off waits on a stalled output.
module angle_bias_kalman_filter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] measured_angle, [63:32] angular_rate, [79:64] time_step
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] angle_estimate, [63:32] bias_estimate
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  abkf_pkg::cmd_t    cmd;
  abkf_pkg::status_t status;
  logic signed [31:0] angle_est, bias_est;

  assign cfg_ready_o = 1'b1;

  abkf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  abkf_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .measured_angle_i (s_axis_tdata[31:0]),
    .angular_rate_i   (s_axis_tdata[63:32]),
    .time_step_i      (s_axis_tdata[79:64]),
    .cfg_we_i         (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .angle_estimate_o (angle_est),
    .bias_estimate_o  (bias_est)
  );

  assign m_axis_tdata = {bias_est, angle_est};

endmodule

FILE: hw/rtl/abkf_div.sv
// Restoring divider for the gains: round(p * 2^28 / s), saturated to 32 bits.
module abkf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic        [31:0] den_i,
  input  logic               den_ok_i,
  output logic               done_o,
  output logic signed [31:0] res_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic        [4:0]  cnt_q, cnt_d;
  logic        [31:0] rem_q, rem_d;
  logic        [31:0] low_q, low_d;
  logic        [31:0] quo_q, quo_d;
  logic        [31:0] den_q, den_d;
  logic               neg_q, neg_d;
  logic signed [31:0] res_q, res_d;

  logic        [31:0] mag;
  logic        [59:0] dividend;
  logic        [32:0] trial;
  logic               fit;

  // Apply sign and clamp the quotient magnitude
  function automatic logic signed [31:0] finish(input logic neg, input logic big,
                                                input logic [31:0] q);
    logic signed [31:0] r;
    if (big || q[31]) begin
      r = neg ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      r = neg ? -$signed(q) : $signed(q);
    end
    return r;
  endfunction

  assign mag      = num_i[31] ? 32'(-{num_i[31], num_i}) : num_i;
  assign dividend = {mag, 28'd0} + {29'd0, den_i[31:1]};
  assign trial    = {rem_q, low_q[31]};
  assign fit      = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    res_d  = res_q;
    if (start_i) begin
      // Take the operands; settle the trivial cases at once
      neg_d = num_i[31];
      den_d = den_i;
      rem_d = {4'd0, dividend[59:32]};
      low_d = dividend[31:0];
      quo_d = '0;
      cnt_d = '0;
      if (!den_ok_i) begin
        res_d  = '0;
        done_d = 1'b1;
      end else if ({4'd0, dividend[59:32]} >= den_i) begin
        res_d  = finish(num_i[31], 1'b1, '0);
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      // One quotient bit per cycle
      rem_d = fit ? 32'(trial - {1'b0, den_q}) : trial[31:0];
      low_d = {low_q[30:0], 1'b0};
      quo_d = {quo_q[30:0], fit};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = finish(neg_q, 1'b0, {quo_q[30:0], fit});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: hw/rtl/abkf_datapath.sv
// Datapath: filter state, noise registers, shared multiplier and gain divider.
module abkf_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  abkf_pkg::cmd_t        cmd_i,
  output abkf_pkg::status_t     status_o,
  input  logic signed [31:0]    measured_angle_i,
  input  logic signed [31:0]    angular_rate_i,
  input  logic        [15:0]    time_step_i,
  input  logic                  cfg_we_i,
  input  logic        [1:0]     cfg_index_i,
  input  logic        [31:0]    cfg_data_i,
  output logic signed [31:0]    angle_estimate_o,
  output logic signed [31:0]    bias_estimate_o
);

  logic        [30:0] an_q, bn_q, mn_q;
  logic signed [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [31:0] ang_d, bias_d, p00_d, p01_d, p10_d, p11_d;
  logic signed [31:0] meas_q, rate_q, inv_q, inv_d, k0_q, k1_q;
  logic        [15:0] dt_q;
  logic signed [32:0] t_q, t_d, s_q, s_d;
  logic signed [68:0] prod_q;
  logic signed [31:0] out_ang_q, out_bias_q;

  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [33:0] dt_s;
  logic signed [71:0] prod_w, r16, r28, t_w;
  logic               div_done;
  logic signed [31:0] div_res;
  logic signed [31:0] div_num;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      an_q <= abkf_pkg::AngleNoiseRst;
      bn_q <= abkf_pkg::BiasNoiseRst;
      mn_q <= abkf_pkg::MeasureNoiseRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        abkf_pkg::RegAngleNoise:   an_q <= cfg_data_i[30:0];
        abkf_pkg::RegBiasNoise:    bn_q <= cfg_data_i[30:0];
        abkf_pkg::RegMeasureNoise: mn_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Select multiplier operands
  assign dt_s = {18'd0, dt_q};
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      abkf_pkg::OP_M_ANG: begin
        mul_a = 36'({{4{rate_q[31]}}, rate_q} - {{4{bias_q[31]}}, bias_q});
        mul_b = dt_s[32:0];
      end
      abkf_pkg::OP_M_T: begin
        mul_a = {{4{p11_q[31]}}, p11_q};
        mul_b = dt_s[32:0];
      end
      abkf_pkg::OP_M_P00: begin
        mul_a = 36'({{3{t_q[32]}}, t_q} - {{4{p01_q[31]}}, p01_q}
                    - {{4{p10_q[31]}}, p10_q} + {5'd0, an_q});
        mul_b = dt_s[32:0];
      end
      abkf_pkg::OP_M_P11: begin
        mul_a = {5'd0, bn_q};
        mul_b = dt_s[32:0];
      end
      abkf_pkg::OP_M_A: begin
        mul_a = {{4{k0_q[31]}}, k0_q};
        mul_b = {inv_q[31], inv_q};
      end
      abkf_pkg::OP_M_B: begin
        mul_a = {{4{k1_q[31]}}, k1_q};
        mul_b = {inv_q[31], inv_q};
      end
      abkf_pkg::OP_M_C: begin
        mul_a = {{4{k1_q[31]}}, k1_q};
        mul_b = {p01_q[31], p01_q};
      end
      abkf_pkg::OP_M_D: begin
        mul_a = {{4{k0_q[31]}}, k0_q};
        mul_b = {p01_q[31], p01_q};
      end
      abkf_pkg::OP_M_E: begin
        mul_a = {{4{k1_q[31]}}, k1_q};
        mul_b = {p00_q[31], p00_q};
      end
      abkf_pkg::OP_M_F: begin
        mul_a = {{4{k0_q[31]}}, k0_q};
        mul_b = {p00_q[31], p00_q};
      end
      default: ;
    endcase
  end

  // Round the registered product to nearest, ties upward
  assign prod_w = {{3{prod_q[68]}}, prod_q};
  assign r16    = (prod_w + 72'sd32768) >>> 16;
  assign r28    = (prod_w + 72'sd134217728) >>> 28;
  assign t_w    = {{39{t_q[32]}}, t_q};

  // Write back results of each operation
  always_comb begin
    ang_d  = ang_q;
    bias_d = bias_q;
    p00_d  = p00_q;
    p01_d  = p01_q;
    p10_d  = p10_q;
    p11_d  = p11_q;
    t_d    = t_q;
    s_d    = s_q;
    inv_d  = inv_q;
    case (cmd_i.op)
      abkf_pkg::OP_W_ANG: ang_d = abkf_pkg::sat32(abkf_pkg::sx32(ang_q) + r16);
      abkf_pkg::OP_W_T:   t_d   = r16[32:0];
      abkf_pkg::OP_W_P00: begin
        p00_d = abkf_pkg::sat32(abkf_pkg::sx32(p00_q) + r16);
        p01_d = abkf_pkg::sat32(abkf_pkg::sx32(p01_q) - t_w);
        p10_d = abkf_pkg::sat32(abkf_pkg::sx32(p10_q) - t_w);
      end
      abkf_pkg::OP_W_P11: begin
        p11_d = abkf_pkg::sat32(abkf_pkg::sx32(p11_q) + r16);
        inv_d = abkf_pkg::sat32(abkf_pkg::sx32(meas_q) - abkf_pkg::sx32(ang_q));
        s_d   = {p00_q[31], p00_q} + {2'd0, mn_q};
      end
      abkf_pkg::OP_W_A: ang_d  = abkf_pkg::sat32(abkf_pkg::sx32(ang_q) + r28);
      abkf_pkg::OP_W_B: bias_d = abkf_pkg::sat32(abkf_pkg::sx32(bias_q) + r28);
      abkf_pkg::OP_W_C: p11_d  = abkf_pkg::sat32(abkf_pkg::sx32(p11_q) - r28);
      abkf_pkg::OP_W_D: p01_d  = abkf_pkg::sat32(abkf_pkg::sx32(p01_q) - r28);
      abkf_pkg::OP_W_E: p10_d  = abkf_pkg::sat32(abkf_pkg::sx32(p10_q) - r28);
      abkf_pkg::OP_W_F: p00_d  = abkf_pkg::sat32(abkf_pkg::sx32(p00_q) - r28);
      default: ;
    endcase
  end

  // Filter state, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_q  <= '0;
      bias_q <= '0;
      p00_q  <= '0;
      p01_q  <= '0;
      p10_q  <= '0;
      p11_q  <= '0;
    end else begin
      ang_q  <= ang_d;
      bias_q <= bias_d;
      p00_q  <= p00_d;
      p01_q  <= p01_d;
      p10_q  <= p10_d;
      p11_q  <= p11_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    t_q    <= t_d;
    s_q    <= s_d;
    inv_q  <= inv_d;
    if (cmd_i.load) begin
      meas_q <= measured_angle_i;
      rate_q <= angular_rate_i;
      dt_q   <= time_step_i;
    end
    if (div_done) begin
      if (cmd_i.op == abkf_pkg::OP_DIV0) begin
        k0_q <= div_res;
      end else begin
        k1_q <= div_res;
      end
    end
    if (cmd_i.out_load) begin
      out_ang_q  <= ang_q;
      out_bias_q <= bias_q;
    end
  end

  // Gain divider: P00 / S first, then P10 / S
  assign div_num = (cmd_i.op == abkf_pkg::OP_DIV0) ? p00_q : p10_q;

  abkf_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_start),
    .num_i    (div_num),
    .den_i    (s_q[31:0]),
    .den_ok_i (!s_q[32] && (s_q != '0)),
    .done_o   (div_done),
    .res_o    (div_res)
  );

  assign status_o.div_done = div_done;
  assign angle_estimate_o  = out_ang_q;
  assign bias_estimate_o   = out_bias_q;

endmodule

FILE: hw/rtl/abkf_ctrl.sv
// Controller: sequences the datapath operations and runs both handshakes.
module abkf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output abkf_pkg::cmd_t    cmd_o,
  input  abkf_pkg::status_t status_i
);

  abkf_pkg::state_e state_q, state_d;
  logic [4:0]       step_q, step_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    out_valid_d  = out_valid_q;
    cmd_o.load      = 1'b0;
    cmd_o.op        = abkf_pkg::OP_NOP;
    cmd_o.div_start = 1'b0;
    cmd_o.out_load  = 1'b0;
    in_ready_o   = 1'b0;

    // Drop the result once the downstream side takes it
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      abkf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = abkf_pkg::ST_STEP;
        end
      end
      abkf_pkg::ST_STEP: begin
        cmd_o.op = abkf_pkg::op_e'(step_q);
        if (cmd_o.op == abkf_pkg::OP_DIV0 || cmd_o.op == abkf_pkg::OP_DIV1) begin
          cmd_o.div_start = 1'b1;
          state_d         = abkf_pkg::ST_DIVW;
        end else if (step_q == abkf_pkg::LastStep) begin
          state_d = abkf_pkg::ST_OUT;
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      abkf_pkg::ST_DIVW: begin
        // Hold the division operation until the gain is ready
        cmd_o.op = abkf_pkg::op_e'(step_q);
        if (status_i.div_done) begin
          step_d  = step_q + 5'd1;
          state_d = abkf_pkg::ST_STEP;
        end
      end
      abkf_pkg::ST_OUT: begin
        // Load the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = abkf_pkg::ST_IDLE;
        end
      end
      default: state_d = abkf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= abkf_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/abkf_checker.sv
// Port-level checker of the Kalman filter top, bound to the top level.
module abkf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // A stalled result holds its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // After an accepted transaction the input does not reopen at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input reopened too early");

  // A new result appears only as the block finishes an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result without work in progress");

endmodule

bind angle_bias_kalman_filter_top abkf_checker u_abkf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: sim/angle_bias_kalman_filter_top_tb.sv
// Self-checking testbench of the angle and gyro bias Kalman filter top level.
`timescale 1ns / 1ps

module angle_bias_kalman_filter_top_tb;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned NumRandom  = 1250;

  // High field first so the struct lines up with tdata
  typedef struct packed {
    logic signed [31:0] bias;
    logic signed [31:0] angle;
  } estimate_t;

  typedef struct {
    logic [31:0] meas;
    logic [31:0] rate;
    logic [15:0] dt;
    logic        known;
    estimate_t   exp_est;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  angle_bias_kalman_filter_top dut (.*);

  // Filter state of the predictor
  logic [30:0]        q_angle, q_bias, r_meas;
  logic signed [31:0] st_angle, st_bias, p_aa, p_ab, p_ba, p_bb;

  estimate_t   estimate_q[$];
  int unsigned n_errors;
  int unsigned idle_cycles;
  bit          hold_rx;
  bit          no_idle;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Saturate to the signed 32-bit range
  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  // Round to nearest, ties toward plus infinity
  function automatic longint rshift_rnd(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // Gain = round(p * 2^28 / s), ties away from zero, saturated
  function automatic logic signed [31:0] kalman_gain(input longint p, input longint s);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (p < 0 ? -p : p);
    mag = mag << 28;
    q = (mag + s / 2) / s;
    if (q > 64'd2147483648) q = 64'd2147483648;
    return clamp32(p < 0 ? -longint'(q) : longint'(q));
  endfunction

  // Advance the predictor by one sample and return the corrected estimate
  function automatic estimate_t filter_step(input logic [31:0] meas_u,
                                            input logic [31:0] rate_u,
                                            input logic [15:0] dt_u);
    longint meas, rate, dt, p00, p01, p10, p11, t, inner, s, k0, k1, ang, inn;
    estimate_t r;
    meas = longint'($signed(meas_u));
    rate = longint'($signed(rate_u));
    dt   = longint'(dt_u);
    p00 = p_aa; p01 = p_ab; p10 = p_ba; p11 = p_bb;
    ang = clamp32(st_angle + rshift_rnd((rate - st_bias) * dt, 16));
    t = rshift_rnd(dt * p11, 16);
    inner = t - p01 - p10 + longint'(q_angle);
    p00 = clamp32(p00 + rshift_rnd(dt * inner, 16));
    p01 = clamp32(p01 - t);
    p10 = clamp32(p10 - t);
    p11 = clamp32(p11 + rshift_rnd(longint'(q_bias) * dt, 16));
    inn = clamp32(meas - ang);
    s = p00 + longint'(r_meas);
    k0 = 0;
    k1 = 0;
    if (s > 0) begin
      k0 = kalman_gain(p00, s);
      k1 = kalman_gain(p10, s);
    end
    st_angle = clamp32(ang + rshift_rnd(k0 * inn, 28));
    st_bias  = clamp32(longint'(st_bias) + rshift_rnd(k1 * inn, 28));
    p_aa = clamp32(p00 - rshift_rnd(k0 * p00, 28));
    p_ab = clamp32(p01 - rshift_rnd(k0 * p01, 28));
    p_ba = clamp32(p10 - rshift_rnd(k1 * p00, 28));
    p_bb = clamp32(p11 - rshift_rnd(k1 * p01, 28));
    r.angle = st_angle;
    r.bias  = st_bias;
    return r;
  endfunction

  // Write one noise register and mirror it in the predictor
  task automatic write_noise(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      abkf_pkg::RegAngleNoise:   q_angle = val[30:0];
      abkf_pkg::RegBiasNoise:    q_bias  = val[30:0];
      abkf_pkg::RegMeasureNoise: r_meas  = val[30:0];
      default: ;
    endcase
  endtask

  // Wait until every expected estimate has come back, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (estimate_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Offer one sample; optionally insert a random gap first
  task automatic send_sample(input logic [31:0] meas, input logic [31:0] rate,
                             input logic [15:0] dt, input bit known,
                             input estimate_t exp_est);
    estimate_t e;
    while (!no_idle && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dt, rate, meas};
    do @(posedge clk_i); while (!s_axis_tready);
    e = filter_step(meas, rate, dt);
    if (known && e !== exp_est) begin
      $error("table row off predictor: exp %h got %h", exp_est, e);
      n_errors++;
    end
    estimate_q.push_back(e);
  endtask

  // Random field value, biased toward the extremes
  function automatic logic [31:0] rnd32();
    case ($urandom_range(9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(4096)) - 2048) <<< 16;
      3: return $urandom;
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [15:0] rnd_dt();
    case ($urandom_range(7))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'($urandom);
      default: return 16'($urandom_range(200, 1));
    endcase
  endfunction

  // Receiver: random backpressure plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_rx && (no_idle || $urandom_range(99) >= 30);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    estimate_t exp_est;
    estimate_t act;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act = m_axis_tdata;
      if (estimate_q.size() == 0) begin
        $error("unexpected result transaction %h", m_axis_tdata);
        n_errors++;
      end else begin
        exp_est = estimate_q.pop_front();
        if (act.angle !== exp_est.angle) begin
          $error("angle_estimate exp %h act %h", exp_est.angle, act.angle);
          n_errors++;
        end
        if (act.bias !== exp_est.bias) begin
          $error("bias_estimate exp %h act %h", exp_est.bias, act.bias);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Hold off the receiver for a long stretch once the block holds two items
  initial begin
    hold_rx = 1'b0;
    while (estimate_q.size() < 2) @(posedge clk_i);
    hold_rx = 1'b1;
    repeat (3000) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    estimate_t zero_est;
    logic [30:0] noise_sets[4][3];

    n_errors = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = abkf_pkg::RegAngleNoise;
    cfg_data_i = '0;
    q_angle = abkf_pkg::AngleNoiseRst;
    q_bias = abkf_pkg::BiasNoiseRst;
    r_meas = abkf_pkg::MeasureNoiseRst;
    {st_angle, st_bias, p_aa, p_ab, p_ba, p_bb} = '0;
    zero_est = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; a zero sample straight after reset stays at zero
    rows.push_back('{32'h0, 32'h0, 16'h0, 1'b1, zero_est});
    rows.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 1'b0, zero_est});
    rows.push_back('{32'h80000000, 32'h80000000, 16'hFFFF, 1'b0, zero_est});
    rows.push_back('{32'h80000000, 32'h7FFFFFFF, 16'h0001, 1'b0, zero_est});
    rows.push_back('{32'h7FFFFFFF, 32'h80000000, 16'h0000, 1'b0, zero_est});
    rows.push_back('{32'h00010000, 32'h00000000, 16'h0148, 1'b0, zero_est});
    rows.push_back('{32'hFFFF0000, 32'h00020000, 16'h8000, 1'b0, zero_est});
    rows.push_back('{32'h55555555, 32'hAAAAAAAA, 16'h5555, 1'b0, zero_est});
    rows.push_back('{32'hAAAAAAAA, 32'h55555555, 16'hAAAA, 1'b0, zero_est});
    foreach (rows[i]) begin
      row = rows[i];
      send_sample(row.meas, row.rate, row.dt, row.known, row.exp_est);
    end
    drain();

    // Zero measurement noise: degenerate innovation covariance on a fresh sample
    write_noise(abkf_pkg::RegMeasureNoise, 32'h0);
    write_noise(abkf_pkg::RegAngleNoise, 32'h0);
    write_noise(abkf_pkg::RegBiasNoise, 32'h0);
    send_sample(32'h00100000, 32'h0, 16'h0, 1'b0, zero_est);
    send_sample(32'h80000000, 32'h7FFFFFFF, 16'hFFFF, 1'b0, zero_est);
    drain();

    // Random phases across several noise settings, extremes among them
    noise_sets[0] = '{abkf_pkg::AngleNoiseRst, abkf_pkg::BiasNoiseRst,
                      abkf_pkg::MeasureNoiseRst};
    noise_sets[1] = '{31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF};
    noise_sets[2] = '{31'd0, 31'd0, 31'd1};
    noise_sets[3] = '{31'd2684354, 31'd80530, 31'd268435456};
    for (int ph = 0; ph < 4; ph++) begin
      // Top bit of written data is dropped by the block
      write_noise(abkf_pkg::RegAngleNoise, {1'($urandom), noise_sets[ph][0]});
      write_noise(abkf_pkg::RegBiasNoise, {1'($urandom), noise_sets[ph][1]});
      write_noise(abkf_pkg::RegMeasureNoise, {1'($urandom), noise_sets[ph][2]});
      no_idle = (ph == 1);
      for (int n = 0; n < NumRandom / 4; n++) begin
        send_sample(rnd32(), rnd32(), rnd_dt(), 1'b0, zero_est);
      end
      // Sender pauses until every result is back
      drain();
    end
    no_idle = 1'b0;

    if (n_errors == 0 && estimate_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
